FILE: design/sqe_pkg.sv
package sqe_pkg;

	// sprite table size; indexes at or above it are dropped
	localparam int SPRITE_COUNT = 16;
	// half-width 0.033 in Q16.16
	localparam int HALF_WIDTH_Q = 2163;
	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam logic [2:0] REG_CAMERA_X = 3'd0;
	localparam logic [2:0] REG_CAMERA_Y = 3'd1;
	localparam logic [2:0] REG_CAMERA_Z = 3'd2;
	localparam logic [2:0] REG_VIEW_X   = 3'd3;
	localparam logic [2:0] REG_VIEW_Y   = 3'd4;
	localparam logic [2:0] REG_VIEW_Z   = 3'd5;
	localparam logic [2:0] REG_MASK     = 3'd6;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] fall_x;
		logic signed [31:0] fall_y;
		logic signed [31:0] fall_z;
		logic signed [7:0]  sprite;
	} streak_t;

	typedef struct packed {
		logic [1:0]         corner;
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic signed [31:0] depth_key;
		logic [3:0]         sprite_out;
		logic               last;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] camera_x;
		logic signed [31:0] camera_y;
		logic signed [31:0] camera_z;
		logic signed [31:0] view_x;
		logic signed [31:0] view_y;
		logic signed [31:0] view_z;
		logic [15:0]        sprite_valid_mask;
	} cfg_t;

	// one kept streak, handed from front to back
	typedef struct packed {
		logic [29:0]        a_n;      // |dy| normalised
		logic [29:0]        b_n;      // |dx| normalised
		logic               dy_neg;
		logic               dx_pos;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [32:0] hx;       // floor(1.75 * fall)
		logic signed [32:0] hy;
		logic signed [32:0] hz;
		logic signed [31:0] depth_key;
		logic [3:0]         sprite;
	} job_t;

endpackage

FILE: design/sqe_front.sv
module sqe_front import sqe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    push,
	output logic    full,
	input  streak_t streak,
	output logic    job_push,
	output job_t    job,
	input  logic    job_full
);

	function automatic logic [5:0] lead_pos(input logic [32:0] m);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 33; i++) begin
			if (m[i]) p = 6'(i);
		end
		return p;
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1: offsets from camera
	streak_t            st_s1;
	logic signed [32:0] dx_s1, dy_s1, dz_s1;

	// stage 2: products
	streak_t            st_s2;
	logic signed [64:0] cpx_s2, cpy_s2, cpz_s2;
	logic signed [63:0] dpx_s2, dpy_s2, dpz_s2;
	logic signed [32:0] hx_s2, hy_s2, hz_s2;
	logic [32:0]        a_s2, b_s2;
	logic               dyneg_s2, dxpos_s2, ok_s2;

	// stage 3: sums, keep decision
	streak_t            st_s3;
	logic signed [31:0] key_s3;
	logic signed [32:0] hx_s3, hy_s3, hz_s3;
	logic [32:0]        a_s3, b_s3, m_s3;
	logic               dyneg_s3, dxpos_s3;

	// stage 4: leading one of the larger magnitude
	streak_t            st_s4;
	logic signed [31:0] key_s4;
	logic signed [32:0] hx_s4, hy_s4, hz_s4;
	logic [32:0]        a_s4, b_s4;
	logic [5:0]         lp_s4;
	logic               dyneg_s4, dxpos_s4;

	logic signed [66:0] cull_sum;
	logic signed [65:0] depth_sum;
	logic signed [49:0] depth_sh;
	logic signed [31:0] depth_sat;
	logic signed [34:0] fx7, fy7, fz7;
	logic [32:0]        m_c, a_sh, b_sh;
	logic               keep_c, spr_ok;

	assign en       = !(v_s4 && job_full);
	assign full     = !en;
	assign job_push = v_s4 && !job_full;

	always_comb begin
		spr_ok = (st_s1.sprite >= 8'sd0) && (st_s1.sprite < 8'(SPRITE_COUNT))
			&& (st_s1.sprite < 8'sd16) && cfg.sprite_valid_mask[st_s1.sprite[3:0]];
		fx7 = 35'(st_s1.fall_x) * 35'sd7;
		fy7 = 35'(st_s1.fall_y) * 35'sd7;
		fz7 = 35'(st_s1.fall_z) * 35'sd7;
	end

	always_comb begin
		cull_sum  = 67'(cpx_s2) + 67'(cpy_s2) + 67'(cpz_s2);
		depth_sum = 66'(dpx_s2) + 66'(dpy_s2) + 66'(dpz_s2);
		depth_sh  = 50'(depth_sum >>> 16);
		if (depth_sh > 50'sd2147483647)
			depth_sat = 32'sh7fffffff;
		else if (depth_sh < -50'sd2147483648)
			depth_sat = 32'sh80000000;
		else
			depth_sat = 32'(depth_sh);
		m_c    = (a_s2 > b_s2) ? a_s2 : b_s2;
		keep_c = ok_s2 && cull_sum[66] && (m_c != '0);
	end

	// bring the larger magnitude to [2^29, 2^30)
	always_comb begin
		if (lp_s4 > 6'd29) begin
			a_sh = a_s4 >> (lp_s4 - 6'd29);
			b_sh = b_s4 >> (lp_s4 - 6'd29);
		end else begin
			a_sh = a_s4 << (6'd29 - lp_s4);
			b_sh = b_s4 << (6'd29 - lp_s4);
		end
		job.a_n       = a_sh[29:0];
		job.b_n       = b_sh[29:0];
		job.dy_neg    = dyneg_s4;
		job.dx_pos    = dxpos_s4;
		job.pos_x     = st_s4.pos_x;
		job.pos_y     = st_s4.pos_y;
		job.pos_z     = st_s4.pos_z;
		job.hx        = hx_s4;
		job.hy        = hy_s4;
		job.hz        = hz_s4;
		job.depth_key = key_s4;
		job.sprite    = st_s4.sprite[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && keep_c;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= streak;
			dx_s1 <= 33'(streak.pos_x) - 33'(cfg.camera_x);
			dy_s1 <= 33'(streak.pos_y) - 33'(cfg.camera_y);
			dz_s1 <= 33'(streak.pos_z) - 33'(cfg.camera_z);

			st_s2    <= st_s1;
			cpx_s2   <= 65'(dx_s1) * 65'(cfg.view_x);
			cpy_s2   <= 65'(dy_s1) * 65'(cfg.view_y);
			cpz_s2   <= 65'(dz_s1) * 65'(cfg.view_z);
			dpx_s2   <= 64'(st_s1.pos_x) * 64'(cfg.view_x);
			dpy_s2   <= 64'(st_s1.pos_y) * 64'(cfg.view_y);
			dpz_s2   <= 64'(st_s1.pos_z) * 64'(cfg.view_z);
			hx_s2    <= 33'(fx7 >>> 2);
			hy_s2    <= 33'(fy7 >>> 2);
			hz_s2    <= 33'(fz7 >>> 2);
			a_s2     <= dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
			b_s2     <= dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
			dyneg_s2 <= dy_s1[32];
			dxpos_s2 <= !dx_s1[32] && (dx_s1 != '0);
			ok_s2    <= spr_ok;

			st_s3    <= st_s2;
			key_s3   <= depth_sat;
			hx_s3    <= hx_s2;
			hy_s3    <= hy_s2;
			hz_s3    <= hz_s2;
			a_s3     <= a_s2;
			b_s3     <= b_s2;
			m_s3     <= m_c;
			dyneg_s3 <= dyneg_s2;
			dxpos_s3 <= dxpos_s2;

			st_s4    <= st_s3;
			key_s4   <= key_s3;
			hx_s4    <= hx_s3;
			hy_s4    <= hy_s3;
			hz_s4    <= hz_s3;
			a_s4     <= a_s3;
			b_s4     <= b_s3;
			lp_s4    <= lead_pos(m_s3);
			dyneg_s4 <= dyneg_s3;
			dxpos_s4 <= dxpos_s3;
		end
	end

endmodule

FILE: design/sqe_fifo.sv
module sqe_fifo import sqe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_data,
	output logic full,
	input  logic rd,
	output job_t rd_data,
	output logic empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	job_t            mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;
	logic            do_wr, do_rd;

	assign full    = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == PW'(QUEUE_DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == PW'(QUEUE_DEPTH-1)) ? '0 : rp_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end

endmodule

FILE: design/sqe_back.sv
module sqe_back import sqe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  job_t    job_head,
	input  logic    job_empty,
	output logic    job_pop,
	output vertex_t quad_vtx,
	output logic    empty,
	input  logic    pop
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQR  = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_ROOT = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	// one digit of the bitwise square root: {rem, res}
	function automatic logic [123:0] root_step(input logic [60:0] n, input logic [62:0] r,
			input logic [4:0] k);
		logic [62:0] one_v;
		logic [62:0] t;
		logic [60:0] n_o;
		logic [62:0] r_o;
		one_v = 63'(1) << {k, 1'b0};
		t     = r + one_v;
		if ({2'b00, n} >= t) begin
			n_o = n - t[60:0];
			r_o = (r >> 1) + one_v;
		end else begin
			n_o = n;
			r_o = r >> 1;
		end
		return {n_o, r_o};
	endfunction

	// one restoring division digit: {rem, quotient bit}
	function automatic logic [42:0] div_step(input logic [41:0] rm, input logic [30:0] d,
			input logic [3:0] i);
		logic [41:0] t;
		t = 42'(d) << i;
		if (rm >= t)
			return {rm - t, 1'b1};
		else
			return {rm, 1'b0};
	endfunction

	function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
		if (v > 35'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -35'sd2147483648)
			return 32'sh80000000;
		else
			return 32'(v);
	endfunction

	logic [2:0]  state_q;
	logic [4:0]  k_q;
	logic [2:0]  di_q;
	job_t        job_q;
	logic [59:0] sqa_q, sqb_q;
	logic [41:0] numx_q, numy_q, remx_q, remy_q;
	logic [60:0] rem_q;
	logic [62:0] res_q;
	logic [11:0] qx_q, qy_q;

	logic               ov_q;
	logic [1:0]         cnt_q;
	job_t               o_job_q;
	logic signed [12:0] o_perpx_q, o_perpy_q;

	logic [123:0] rs1, rs2;
	logic [42:0]  dx1, dx2, dy1, dy2;
	logic [3:0]   i0, i1;
	logic [30:0]  root;
	logic         load_ok, do_load, out_take;
	logic         use_perp, use_fall;
	logic signed [34:0] sx, sy, sz;

	assign job_pop  = (state_q == ST_IDLE) && !job_empty;
	assign out_take = pop && ov_q;
	assign load_ok  = !ov_q || (out_take && (cnt_q == 2'd3));
	assign do_load  = (state_q == ST_DONE) && load_ok;
	assign root     = res_q[30:0];
	assign i0       = 4'd11 - {di_q, 1'b0};
	assign i1       = i0 - 4'd1;

	always_comb begin
		rs1 = root_step(rem_q, res_q, k_q);
		rs2 = root_step(rs1[123:63], rs1[62:0], k_q - 5'd1);
		dx1 = div_step(remx_q, root, i0);
		dx2 = div_step(dx1[42:1], root, i1);
		dy1 = div_step(remy_q, root, i0);
		dy2 = div_step(dy1[42:1], root, i1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			di_q    <= '0;
			ov_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!job_empty) state_q <= ST_SQR;
				end
				ST_SQR: state_q <= ST_SUM;
				ST_SUM: begin
					state_q <= ST_ROOT;
					k_q     <= 5'd31;
				end
				ST_ROOT: begin
					k_q <= k_q - 5'd2;
					if (k_q == 5'd1) begin
						state_q <= ST_DIV;
						di_q    <= '0;
					end
				end
				ST_DIV: begin
					di_q <= di_q + 3'd1;
					if (di_q == 3'd5) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_ok) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (do_load) begin
				ov_q  <= 1'b1;
				cnt_q <= '0;
			end else if (out_take) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) job_q <= job_head;
		unique case (state_q)
			ST_SQR: begin
				sqa_q  <= 60'(job_q.a_n) * 60'(job_q.a_n);
				sqb_q  <= 60'(job_q.b_n) * 60'(job_q.b_n);
				numx_q <= 42'(job_q.a_n) * 42'(HALF_WIDTH_Q);
				numy_q <= 42'(job_q.b_n) * 42'(HALF_WIDTH_Q);
			end
			ST_SUM: begin
				rem_q  <= 61'(sqa_q) + 61'(sqb_q);
				res_q  <= '0;
				remx_q <= numx_q;
				remy_q <= numy_q;
				qx_q   <= '0;
				qy_q   <= '0;
			end
			ST_ROOT: begin
				rem_q <= rs2[123:63];
				res_q <= rs2[62:0];
			end
			ST_DIV: begin
				remx_q <= dx2[42:1];
				remy_q <= dy2[42:1];
				qx_q   <= {qx_q[9:0], dx1[0], dx2[0]};
				qy_q   <= {qy_q[9:0], dy1[0], dy2[0]};
			end
			default: ;
		endcase
		if (do_load) begin
			o_job_q   <= job_q;
			o_perpx_q <= job_q.dy_neg ? -13'(qx_q) : 13'(qx_q);
			o_perpy_q <= job_q.dx_pos ? -13'(qy_q) : 13'(qy_q);
		end
	end

	// corner 0 = pos, 1 = +perp, 2 = +perp+fall, 3 = +fall
	always_comb begin
		use_perp = (cnt_q == 2'd1) || (cnt_q == 2'd2);
		use_fall = (cnt_q == 2'd2) || (cnt_q == 2'd3);
		sx = 35'(o_job_q.pos_x) + (use_perp ? 35'(o_perpx_q) : 35'sd0)
			+ (use_fall ? 35'(o_job_q.hx) : 35'sd0);
		sy = 35'(o_job_q.pos_y) + (use_perp ? 35'(o_perpy_q) : 35'sd0)
			+ (use_fall ? 35'(o_job_q.hy) : 35'sd0);
		sz = 35'(o_job_q.pos_z) + (use_fall ? 35'(o_job_q.hz) : 35'sd0);
		quad_vtx.corner     = cnt_q;
		quad_vtx.vertex_x   = sat35(sx);
		quad_vtx.vertex_y   = sat35(sy);
		quad_vtx.vertex_z   = sat35(sz);
		quad_vtx.depth_key  = o_job_q.depth_key;
		quad_vtx.sprite_out = o_job_q.sprite;
		quad_vtx.last       = (cnt_q == 2'd3);
	end

	assign empty = !ov_q;

endmodule

FILE: design/streak_quad_expand.sv
// channel   | handshake                | word
// ----------+--------------------------+---------------------------------------
// streak in | push / full              | streak_t: pos, fall, sprite
// quad out  | pop / empty              | vertex_t: corner, vertex, key, last
// config    | cfg_valid / cfg_ready    | cfg_index (3b), cfg_data (32b)
//
// Front: four-stage pipe, one streak a cycle while full is low; culled or
// dropped streaks give no words. Back: a kept streak holds the root/divide unit
// through pop, square, sum, 16 x two root digits, 6 x two quotient digits and
// load; its corners drain from the output register while the next computes.
// Reset clears control and config registers, no clearing pass. Full rises once
// the two-word queue is full and the last front stage holds a word.
module streak_quad_expand import sqe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  streak_t     streak,
	output logic        empty,
	input  logic        pop,
	output vertex_t     quad_vtx,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t cfg_q;
	job_t fr_job, q_head;
	logic fr_push, q_full, q_empty, q_pop;

	// config to be written only while idle (a rule for the user, not enforced here), so always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CAMERA_X: cfg_q.camera_x <= cfg_data;
				REG_CAMERA_Y: cfg_q.camera_y <= cfg_data;
				REG_CAMERA_Z: cfg_q.camera_z <= cfg_data;
				REG_VIEW_X:   cfg_q.view_x   <= cfg_data;
				REG_VIEW_Y:   cfg_q.view_y   <= cfg_data;
				REG_VIEW_Z:   cfg_q.view_z   <= cfg_data;
				REG_MASK:     cfg_q.sprite_valid_mask <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// cull, sprite check, depth key and normalisation
	sqe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.full     (full),
		.streak   (streak),
		.job_push (fr_push),
		.job      (fr_job),
		.job_full (q_full)
	);

	sqe_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fr_push),
		.wr_data (fr_job),
		.full    (q_full),
		.rd      (q_pop),
		.rd_data (q_head),
		.empty   (q_empty)
	);

	// reciprocal length, width vector, corner emission
	sqe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_head  (q_head),
		.job_empty (q_empty),
		.job_pop   (q_pop),
		.quad_vtx  (quad_vtx),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

FILE: test/tb_streak_quad_expand.sv
module tb_streak_quad_expand;
	import sqe_pkg::*;

	// clock, reset and block ports; every input starts at a known value
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	streak_t     streak = '0;
	logic        empty;
	logic        pop = 1'b0;
	vertex_t     quad_vtx;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_CAMERA_X;
	logic [31:0] cfg_data = '0;

	// streaks waiting to be offered, corners still owed by the block
	streak_t pending[$];
	vertex_t corner_q[$];
	// shadow of the register file, as the block should hold it
	cfg_t    shadow = '0;

	int  errors = 0;
	int  streaks_sent = 0;
	int  corners_seen = 0;
	int  hold_cnt = 0;
	bit  pause = 1'b0;    // sender holds off while set
	bit  calm = 1'b0;     // no random idling on either side while set
	bit  hold_go = 1'b0;  // starts the long receiver hold-off

	streak_quad_expand dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .streak(streak),
		.empty(empty), .pop(pop), .quad_vtx(quad_vtx),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// integer square root, floor, bit by bit
	function automatic logic [63:0] root64(logic [63:0] n);
		logic [63:0] res, bit_w;
		res = '0;
		bit_w = 64'd1 << 62;
		while (bit_w > n)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (n >= res + bit_w) begin
				n = n - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
		if (v > 128'sd2147483647)
			return 32'sh7fffffff;
		if (v < -128'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// works out the four corners of one streak under the shadow settings;
	// culled, badly indexed, masked and zero-width streaks give nothing
	function automatic void expand_streak(streak_t s);
		longint px, py, pz, dx, dy, dz, vx, vy, vz, hx, hy, hz, perpx, perpy;
		longint cx[4], cy[4], cz[4];
		logic signed [127:0] cull, dk;
		logic [63:0] a, b, m, r, qx, qy;
		logic signed [31:0] key;
		vertex_t v;
		px = s.pos_x; py = s.pos_y; pz = s.pos_z;
		vx = shadow.view_x; vy = shadow.view_y; vz = shadow.view_z;
		dx = px - longint'(shadow.camera_x);
		dy = py - longint'(shadow.camera_y);
		dz = pz - longint'(shadow.camera_z);
		cull = 128'(dx) * 128'(vx) + 128'(dy) * 128'(vy) + 128'(dz) * 128'(vz);
		// kept only when strictly in front of the camera
		if (cull >= 0)
			return;
		if (s.sprite < 0 || s.sprite >= SPRITE_COUNT)
			return;
		if (!shadow.sprite_valid_mask[s.sprite[3:0]])
			return;
		a = dy < 0 ? -dy : dy;
		b = dx < 0 ? -dx : dx;
		m = a > b ? a : b;
		if (m == 0)
			return;
		// bring the larger leg into [2^29, 2^30), truncating on the way down
		while (m >= (64'd1 << 30)) begin
			a = a >> 1; b = b >> 1; m = m >> 1;
		end
		while (m < (64'd1 << 29)) begin
			a = a << 1; b = b << 1; m = m << 1;
		end
		r = root64(a * a + b * b);
		qx = (a * HALF_WIDTH_Q) / r;
		qy = (b * HALF_WIDTH_Q) / r;
		perpx = dy < 0 ? -longint'(qx) : longint'(qx);
		perpy = dx > 0 ? -longint'(qy) : longint'(qy);
		// 1.75 * fall, floored: arithmetic shift floors negatives too
		hx = (longint'(s.fall_x) * 7) >>> 2;
		hy = (longint'(s.fall_y) * 7) >>> 2;
		hz = (longint'(s.fall_z) * 7) >>> 2;
		dk = 128'(px) * 128'(vx) + 128'(py) * 128'(vy) + 128'(pz) * 128'(vz);
		key = clamp32(dk >>> 16);
		cx[0] = px;              cy[0] = py;              cz[0] = pz;
		cx[1] = px + perpx;      cy[1] = py + perpy;      cz[1] = pz;
		cx[2] = px + perpx + hx; cy[2] = py + perpy + hy; cz[2] = pz + hz;
		cx[3] = px + hx;         cy[3] = py + hy;         cz[3] = pz + hz;
		for (int k = 0; k < 4; k++) begin
			v.corner = 2'(k);
			v.vertex_x = clamp32(128'(cx[k]));
			v.vertex_y = clamp32(128'(cy[k]));
			v.vertex_z = clamp32(128'(cz[k]));
			v.depth_key = key;
			v.sprite_out = s.sprite[3:0];
			v.last = (k == 3);
			corner_q.push_back(v);
		end
	endfunction

	// sender: offers the oldest pending streak, holds it until taken
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				expand_streak(streak);
				void'(pending.pop_front());
				streaks_sent++;
			end
			if (push && full) begin
				push <= 1'b1;        // word not taken yet, keep offering it
			end else if (!pause && pending.size() > 0 &&
					(calm || $urandom_range(99) >= 32)) begin
				push <= 1'b1;
				streak <= pending[0];
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: checks every corner word taken against the oldest owed one
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				corners_seen++;
				if (corner_q.size() == 0) begin
					errors++;
					$display("%0t unexpected corner word: corner=%0d x=%0d y=%0d z=%0d",
						$time, quad_vtx.corner, quad_vtx.vertex_x,
						quad_vtx.vertex_y, quad_vtx.vertex_z);
				end else begin
					if (quad_vtx !== corner_q[0]) begin
						errors++;
						$display("%0t mismatch exp: c=%0d x=%0d y=%0d z=%0d key=%0d spr=%0d last=%0b",
							$time, corner_q[0].corner, corner_q[0].vertex_x,
							corner_q[0].vertex_y, corner_q[0].vertex_z,
							corner_q[0].depth_key, corner_q[0].sprite_out,
							corner_q[0].last);
						$display("%0t mismatch got: c=%0d x=%0d y=%0d z=%0d key=%0d spr=%0d last=%0b",
							$time, quad_vtx.corner, quad_vtx.vertex_x,
							quad_vtx.vertex_y, quad_vtx.vertex_z,
							quad_vtx.depth_key, quad_vtx.sprite_out, quad_vtx.last);
					end
					void'(corner_q.pop_front());
				end
			end
			// long hold-off so the queue and front pipe back up into full
			if (hold_go && hold_cnt < 400) begin
				hold_cnt++;
				pop <= 1'b0;
			end else begin
				pop <= calm || $urandom_range(99) >= 32;
			end
		end
	end

	// one register write; valid stays up into the next write, caller lowers it
	task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_CAMERA_X: shadow.camera_x = data;
			REG_CAMERA_Y: shadow.camera_y = data;
			REG_CAMERA_Z: shadow.camera_z = data;
			REG_VIEW_X:   shadow.view_x = data;
			REG_VIEW_Y:   shadow.view_y = data;
			REG_VIEW_Z:   shadow.view_z = data;
			REG_MASK:     shadow.sprite_valid_mask = data[15:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(cfg_t c);
		cfg_write(REG_CAMERA_X, c.camera_x);
		cfg_write(REG_CAMERA_Y, c.camera_y);
		cfg_write(REG_CAMERA_Z, c.camera_z);
		cfg_write(REG_VIEW_X, c.view_x);
		cfg_write(REG_VIEW_Y, c.view_y);
		cfg_write(REG_VIEW_Z, c.view_z);
		cfg_write(REG_MASK, {16'd0, c.sprite_valid_mask});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// block idle: nothing pending or owed, then room for a dropped
	// streak still in the pipe
	task automatic drain();
		while (pending.size() != 0 || push || corner_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic streak_t mk(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] fx, logic [31:0] fy, logic [31:0] fz, logic [7:0] spr);
		streak_t s;
		s.pos_x = px; s.pos_y = py; s.pos_z = pz;
		s.fall_x = fx; s.fall_y = fy; s.fall_z = fz;
		s.sprite = spr;
		return s;
	endfunction

	// Q16.16 value: full range, near zero, or an extreme
	function automatic logic [31:0] rnd_q();
		case ($urandom_range(3))
			0: return $urandom;
			1, 2: return $urandom_range(32'h0006_0000) - 32'h0003_0000;
			default: begin
				case ($urandom_range(4))
					0: return 32'h7fffffff;
					1: return 32'h80000000;
					2: return 32'h0;
					3: return 32'h1;
					default: return 32'hffffffff;
				endcase
			end
		endcase
	endfunction

	initial begin
		cfg_t c;
		streak_t s;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero view vector, so every streak is culled
		pending.push_back(mk(32'h10000, 32'h20000, 32'hffff0000, 0, 0, 0, 8'd3));
		pending.push_back(mk(32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h0, 8'd0));
		drain();

		// looking down +z from the origin, all sprites usable
		c = '0;
		c.view_z = 32'h10000;
		c.sprite_valid_mask = 16'hffff;
		apply_settings(c);
		pending.push_back(mk(32'h10000, 32'h20000, 32'hffff0000,
			0, 32'hffff0000, 0, 8'd3));
		pending.push_back(mk(32'h7fffffff, 32'h80000000, 32'hffffffff,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 8'd15));
		pending.push_back(mk(32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 8'd0));
		pending.push_back(mk(0, 0, 32'hfffffffb, 32'h10000, 0, 0, 8'd1));  // zero width
		pending.push_back(mk(0, 1, 32'hfffffffb, 0, 0, 32'h10000, 8'd1));  // tiny width
		pending.push_back(mk(32'hffffffff, 0, 32'hfffffff0, 0, 0, 0, 8'd2));
		pending.push_back(mk(32'h10000, 32'h10000, 32'hffff0000, 0, 0, 0, 8'hff));
		pending.push_back(mk(32'h10000, 32'h10000, 32'hffff0000, 0, 0, 0, 8'd16));
		pending.push_back(mk(32'h10000, 32'h10000, 32'hffff0000, 0, 0, 0, 8'h7f));
		pending.push_back(mk(32'h10000, 32'h10000, 32'hffff0000, 0, 0, 0, 8'h80));
		pending.push_back(mk(32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 8'd4));   // behind
		pending.push_back(mk(32'h10000, 32'h10000, 32'h0, 0, 0, 0, 8'd4));       // on plane
		drain();

		// extreme camera and view, every other sprite masked out
		c.camera_x = 32'h7fffffff;
		c.camera_y = 32'h80000000;
		c.camera_z = 32'h7fffffff;
		c.view_x = 32'h80000000;
		c.view_y = 32'h7fffffff;
		c.view_z = 32'h80000000;
		c.sprite_valid_mask = 16'h5555;
		apply_settings(c);
		pending.push_back(mk(32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 8'd2));
		pending.push_back(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0, 0, 8'd1));
		pending.push_back(mk(32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h12345678, 32'hedcba987, 8'd14));
		pending.push_back(mk(32'h00000000, 32'hffffffff, 32'h00000000,
			32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 8'd6));
		pending.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 8'd8));
		drain();

		// random phases, fresh settings each; the first masks every sprite out, the rest set the mask mostly so most live
		for (int ph = 0; ph < 4; ph++) begin
			c.camera_x = rnd_q(); c.camera_y = rnd_q(); c.camera_z = rnd_q();
			c.view_x = rnd_q(); c.view_y = rnd_q(); c.view_z = rnd_q();
			c.sprite_valid_mask = (ph == 0) ? 16'h0000 : 16'($urandom) | 16'hbdef;
			if (ph == 3)
				c.sprite_valid_mask = 16'hffff;
			apply_settings(c);
			calm = (ph == 2);
			for (int i = 0; i < 40; i++) begin
				s = mk(rnd_q(), rnd_q(), rnd_q(), rnd_q(), rnd_q(), rnd_q(),
					$urandom_range(99) < 85 ? 8'($urandom_range(15)) : 8'($urandom));
				pending.push_back(s);
			end
			if (ph == 1)
				hold_go = 1'b1;
			if (ph == 3) begin
				while (pending.size() > 20)
					@(posedge clk);
				pause = 1'b1;
				while (corner_q.size() != 0)
					@(posedge clk);
				pause = 1'b0;
			end
			drain();
		end
		calm = 1'b0;

		$display("streaks accepted: %0d, corner words checked: %0d", streaks_sent,
			corners_seen);
		$display("covered reset, directed and extreme settings, four random settings");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end

endmodule
